// ----- sv/pse_pkg.sv -----
package pse_pkg;

   localparam int FracBits = 16;
   localparam int NormBits = 16;
   localparam int CoordW = 32;
   localparam int HwW = 31;
   localparam int MagW = 33;
   localparam int SqW = 2 * NormBits + 1;
   localparam int RootW = NormBits + 1;
   localparam int QuotW = HwW + 1;
   localparam int DivNumW = HwW + NormBits;
   localparam logic [HwW-1:0] HwReset = HwW'(1) << (FracBits - 1);
   localparam int VertCount = 4;

   typedef logic signed [CoordW-1:0] coord_type;

   // One segment job handed from the front end to the back end.
   typedef struct packed {
      coord_type px;
      coord_type py;
      logic [31:0] pattr;
      coord_type cx;
      coord_type cy;
      logic [31:0] cattr;
   } seg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ROOT,
      BK_DIVX,
      BK_DIVY,
      BK_EMIT
   } bk_state_type;

endpackage

// ----- sv/pse_if.sv -----
interface pse_point_if;
   import pse_pkg::*;
   logic valid;
   logic ready;
   coord_type x;
   coord_type y;
   logic [31:0] attr;
   logic first;
   modport source (output valid, x, y, attr, first, input ready);
   modport sink (input valid, x, y, attr, first, output ready);
endinterface

interface pse_vertex_if;
   import pse_pkg::*;
   logic valid;
   logic ready;
   coord_type vx;
   coord_type vy;
   logic [31:0] vattr;
   logic side;
   logic last;
   modport source (output valid, vx, vy, vattr, side, last, input ready);
   modport sink (input valid, vx, vy, vattr, side, last, output ready);
endinterface

interface pse_csr_if;
   logic valid;
   logic ready;
   logic [30:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- sv/pse_front.sv -----
module pse_front (
   input logic clock,
   input logic reset,
   pse_point_if.sink req,
   output logic seg_valid,
   input logic seg_ready,
   output pse_pkg::seg_type seg
);
   import pse_pkg::*;

   coord_type prev_x_ff, prev_y_ff;
   logic [31:0] prev_attr_ff;
   logic have_prev_ff;
   logic full_ff;
   seg_type seg_ff;
   logic take, emit;

   // One-entry handoff: a point is taken whenever the held segment can leave.
   assign emit = req.valid && !req.first && have_prev_ff;
   assign req.ready = !full_ff || seg_ready;
   assign take = req.valid && req.ready;
   assign seg_valid = full_ff;
   assign seg = seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         prev_attr_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         if (seg_ready) full_ff <= 1'b0;
         if (take) begin
            prev_x_ff <= req.x;
            prev_y_ff <= req.y;
            prev_attr_ff <= req.attr;
            have_prev_ff <= 1'b1;
            if (emit) full_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         seg_ff <= '{px: prev_x_ff, py: prev_y_ff, pattr: prev_attr_ff,
                     cx: req.x, cy: req.y, cattr: req.attr};
      end
   end
endmodule

// ----- sv/pse_back.sv -----
module pse_back (
   input logic clock,
   input logic reset,
   input logic [pse_pkg::HwW-1:0] half_width,
   input logic seg_valid,
   output logic seg_ready,
   input pse_pkg::seg_type seg,
   pse_vertex_if.source rsp
);
   import pse_pkg::*;

   bk_state_type state_ff, state_in;
   seg_type job_ff;
   logic [MagW-1:0] a_ff, b_ff;
   logic dxneg_ff, dypos_ff, zero_ff;
   logic [SqW-1:0] rem_ff;
   logic [RootW-1:0] root_ff;
   logic [5:0] cnt_ff;
   logic [DivNumW-1:0] num_ff;
   logic [DivNumW-1:0] quo_ff;
   logic [RootW:0] drem_ff;
   logic [QuotW-1:0] mx_ff, my_ff;
   logic [1:0] vk_ff;
   logic out_valid_ff;
   logic signed [MagW:0] dx, dy;
   logic [MagW-1:0] am, bm, mm, an, bn;
   logic [5:0] top;
   logic [SqW+1:0] trial;
   logic [RootW:0] dtrial;
   logic [RootW-1:0] len;
   logic signed [CoordW+1:0] ox, oy, bx, by, sx, sy;

   // Difference magnitudes and normalization to NormBits significant bits.
   always_comb begin
      dx = {{2{seg.cx[CoordW-1]}}, seg.cx} - {{2{seg.px[CoordW-1]}}, seg.px};
      dy = {{2{seg.cy[CoordW-1]}}, seg.cy} - {{2{seg.py[CoordW-1]}}, seg.py};
      am = dx[MagW] ? MagW'(-dx) : MagW'(dx);
      bm = dy[MagW] ? MagW'(-dy) : MagW'(dy);
      mm = (am > bm) ? am : bm;
      top = '0;
      for (int i = 0; i < MagW; i++) begin
         if (mm[i]) top = 6'(i);
      end
      if (top > 6'(NormBits - 1)) begin
         an = am >> (top - 6'(NormBits - 1));
         bn = bm >> (top - 6'(NormBits - 1));
      end else begin
         an = am << (6'(NormBits - 1) - top);
         bn = bm << (6'(NormBits - 1) - top);
      end
   end

   assign len = (root_ff == '0) ? RootW'(1) : root_ff;
   assign trial = {2'b00, rem_ff} - {1'b0, root_ff, 2'b01} ;
   assign dtrial = {drem_ff[RootW-1:0], num_ff[DivNumW-1]} - {1'b0, len};

   always_comb begin
      unique case (state_ff)
         BK_IDLE: state_in = seg_valid ? BK_ROOT : BK_IDLE;
         BK_ROOT: state_in = (cnt_ff == '0) ? BK_DIVX : BK_ROOT;
         BK_DIVX: state_in = (cnt_ff == '0) ? BK_DIVY : BK_DIVX;
         BK_DIVY: state_in = (cnt_ff == '0) ? BK_EMIT : BK_DIVY;
         BK_EMIT: state_in = (!out_valid_ff || rsp.ready) && vk_ff == 2'(VertCount - 1)
                             ? BK_IDLE : BK_EMIT;
         default: state_in = BK_IDLE;
      endcase
   end

   assign seg_ready = (state_ff == BK_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         out_valid_ff <= 1'b0;
         vk_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp.ready) out_valid_ff <= 1'b0;
         if (state_ff == BK_EMIT && (!out_valid_ff || rsp.ready)) begin
            out_valid_ff <= 1'b1;
            vk_ff <= vk_ff + 2'd1;
         end
      end
   end

   // Root is restoring, two radicand bits a step; divisions one bit a step.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            job_ff <= seg;
            a_ff <= an;
            b_ff <= bn;
            dxneg_ff <= dx[MagW];
            dypos_ff <= !dx[MagW] && 1'b0 || (!dy[MagW] && dy != '0);
            zero_ff <= (mm == '0);
            rem_ff <= SqW'(an[NormBits-1:0]) * SqW'(an[NormBits-1:0])
                      + SqW'(bn[NormBits-1:0]) * SqW'(bn[NormBits-1:0]);
            root_ff <= '0;
            cnt_ff <= 6'(RootW - 1);
         end
         BK_ROOT: begin
            if (!trial[SqW+1] && (rem_ff >> (2 * cnt_ff)) >= SqW'({root_ff, 2'b01})) begin
               rem_ff <= rem_ff - (SqW'({root_ff, 2'b01}) << (2 * cnt_ff));
               root_ff <= {root_ff[RootW-2:0], 1'b1};
            end else begin
               root_ff <= {root_ff[RootW-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               num_ff <= DivNumW'(half_width) * DivNumW'(b_ff[NormBits-1:0]);
               drem_ff <= '0;
               cnt_ff <= 6'(DivNumW - 1);
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
         BK_DIVX, BK_DIVY: begin
            if (!dtrial[RootW]) begin
               drem_ff <= dtrial;
               quo_ff <= {quo_ff[DivNumW-2:0], 1'b1};
            end else begin
               drem_ff <= {drem_ff[RootW-1:0], num_ff[DivNumW-1]};
               quo_ff <= {quo_ff[DivNumW-2:0], 1'b0};
            end
            num_ff <= num_ff << 1;
            if (cnt_ff == '0) begin
               if (state_ff == BK_DIVX) begin
                  mx_ff <= QuotW'(dtrial[RootW] ? {quo_ff[DivNumW-2:0], 1'b0}
                                                 : {quo_ff[DivNumW-2:0], 1'b1});
                  num_ff <= DivNumW'(half_width) * DivNumW'(a_ff[NormBits-1:0]);
                  drem_ff <= '0;
                  cnt_ff <= 6'(DivNumW - 1);
               end else begin
                  my_ff <= QuotW'(dtrial[RootW] ? {quo_ff[DivNumW-2:0], 1'b0}
                                                 : {quo_ff[DivNumW-2:0], 1'b1});
               end
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
         default: ;
      endcase
   end

   // Vertex output register with saturation.
   always_comb begin
      if (zero_ff) begin
         ox = '0;
         oy = (CoordW+2)'(half_width);
      end else begin
         ox = dypos_ff ? -(CoordW+2)'(mx_ff) : (CoordW+2)'(mx_ff);
         oy = dxneg_ff ? -(CoordW+2)'(my_ff) : (CoordW+2)'(my_ff);
      end
      bx = vk_ff[1] ? (CoordW+2)'(job_ff.cx) : (CoordW+2)'(job_ff.px);
      by = vk_ff[1] ? (CoordW+2)'(job_ff.cy) : (CoordW+2)'(job_ff.py);
      sx = vk_ff[0] ? bx - ox : bx + ox;
      sy = vk_ff[0] ? by - oy : by + oy;
   end

   function automatic coord_type sat(input logic signed [CoordW+1:0] v);
      if (v > (CoordW+2)'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
      if (v < -(CoordW+2)'(33'sh080000000)) return 32'sh80000000;
      return v[CoordW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (state_ff == BK_EMIT && (!out_valid_ff || rsp.ready)) begin
         rsp.vx <= sat(sx);
         rsp.vy <= sat(sy);
         rsp.vattr <= vk_ff[1] ? job_ff.cattr : job_ff.pattr;
         rsp.side <= vk_ff[0];
         rsp.last <= (vk_ff == 2'(VertCount - 1));
      end
   end

   assign rsp.valid = out_valid_ff;
endmodule

// ----- sv/polyline_stroke_extruder_unit.sv -----
// Polyline stroke extruder.
// req carries polyline points (x, y, attr, first); rsp carries strip
// vertices (vx, vy, vattr, side, last); csr writes the 31-bit half width.
// A point with first set, or the first point after reset, is only stored.
// Each later point yields four vertices: previous point plus and minus the
// normal, then this point plus and minus the normal; last marks the fourth.
// A front end stores the previous point and hands a segment to a back end
// through a one-entry queue, so the next point can be taken while the
// previous segment is still being worked on.
// Per segment the back end takes the segment, works out the square root and
// runs two bit-serial divisions, then emits one vertex per cycle while rsp
// is ready. It takes no new segment until its fourth vertex is registered.
// The first vertex is valid only after the root and both divisions.
// Points are accepted at one per cycle while the queue has room.
// When rsp stalls the held vertex stays put and the back end waits.
// Reset (synchronous) drops the stored point and sets the half width to 0.5.
module polyline_stroke_extruder_unit (
   input logic clock,
   input logic reset,
   pse_point_if.sink req,
   pse_vertex_if.source rsp,
   pse_csr_if.sink csr
);
   import pse_pkg::*;

   logic [HwW-1:0] half_width_ff;
   logic seg_valid, seg_ready;
   seg_type seg;

   assign csr.ready = 1'b1;

   // Half width register.
   always_ff @(posedge clock) begin
      if (reset) half_width_ff <= HwReset;
      else if (csr.valid) half_width_ff <= csr.data;
   end

   pse_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg)
   );

   pse_back u_back (
      .clock(clock), .reset(reset), .half_width(half_width_ff),
      .seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg), .rsp(rsp)
   );
endmodule

// ----- sim/testbench.sv -----
module testbench;
   import pse_pkg::*;

   localparam int CycleLimit = 1000000;
   localparam int SettleCycles = 150;

   typedef struct {
      coord_type vx;
      coord_type vy;
      logic [31:0] vattr;
      logic side;
      logic last;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int cycle_count = 0;
   int error_count = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   logic receiver_hold = 1'b0;

   // Stroke state mirrored from the block
   logic [HwW-1:0] stroke_half_width = HwReset;
   coord_type stored_x = '0;
   coord_type stored_y = '0;
   logic [31:0] stored_attr = '0;
   logic stored_valid = 1'b0;
   vertex_type pending_vertices[$];

   pse_point_if req_if();
   pse_vertex_if rsp_if();
   pse_csr_if csr_if();

   polyline_stroke_extruder_unit dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .csr(csr_if)
   );

   always #5 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.x = '0;
      req_if.y = '0;
      req_if.attr = '0;
      req_if.first = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      rsp_if.ready = 1'b0;
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver side: random stalls, plus a long hold when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (receiver_hold) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Compare every accepted vertex beat with the oldest expected vertex.
   always @(posedge clock) begin
      vertex_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_vertices.size() == 0) begin
            $display("%0t: unexpected vertex vx=%h vy=%h", $time, rsp_if.vx, rsp_if.vy);
            error_count++;
         end else begin
            want = pending_vertices.pop_front();
            if (rsp_if.vx !== want.vx) begin
               $display("%0t: vx expected %h actual %h", $time, want.vx, rsp_if.vx);
               error_count++;
            end
            if (rsp_if.vy !== want.vy) begin
               $display("%0t: vy expected %h actual %h", $time, want.vy, rsp_if.vy);
               error_count++;
            end
            if (rsp_if.vattr !== want.vattr) begin
               $display("%0t: vattr expected %h actual %h", $time, want.vattr,
                        rsp_if.vattr);
               error_count++;
            end
            if (rsp_if.side !== want.side) begin
               $display("%0t: side expected %b actual %b", $time, want.side, rsp_if.side);
               error_count++;
            end
            if (rsp_if.last !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_if.last);
               error_count++;
            end
         end
      end
   end

   // Integer square root, bit by bit.
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned bitpos;
      r = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= r + bitpos) begin
            v -= r + bitpos;
            r = (r >> 1) + bitpos;
         end else begin
            r >>= 1;
         end
         bitpos >>= 2;
      end
      return r;
   endfunction

   function automatic coord_type clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   // Scaled perpendicular of the segment (dx, dy).
   task automatic stroke_normal(input longint dx, input longint dy,
                                output longint nx, output longint ny);
      longint unsigned a;
      longint unsigned b;
      longint unsigned m;
      longint unsigned len;
      longint unsigned mx;
      longint unsigned my;
      int top;
      a = dx < 0 ? -dx : dx;
      b = dy < 0 ? -dy : dy;
      m = a > b ? a : b;
      if (m == 0) begin
         nx = 0;
         ny = stroke_half_width;
         return;
      end
      top = 0;
      while (top < 63 && (m >> (top + 1)) != 0) top++;
      if (top > NormBits - 1) begin
         a >>= (top - (NormBits - 1));
         b >>= (top - (NormBits - 1));
      end else begin
         a <<= ((NormBits - 1) - top);
         b <<= ((NormBits - 1) - top);
      end
      len = int_sqrt(a * a + b * b);
      if (len == 0) len = 1;
      mx = (longint'(stroke_half_width) * b) / len;
      my = (longint'(stroke_half_width) * a) / len;
      nx = dy > 0 ? -longint'(mx) : longint'(mx);
      ny = dx < 0 ? -longint'(my) : longint'(my);
   endtask

   // Expected strip vertices for one accepted point.
   task automatic extrude_point(input coord_type x, input coord_type y,
                                input logic [31:0] attr, input logic first);
      longint nx;
      longint ny;
      vertex_type v;
      if (!first && stored_valid) begin
         stroke_normal(longint'(x) - longint'(stored_x), longint'(y) - longint'(stored_y),
                       nx, ny);
         for (int k = 0; k < VertCount; k++) begin
            v.side = k[0];
            v.last = (k == VertCount - 1);
            v.vattr = (k < 2) ? stored_attr : attr;
            v.vx = clamp32((k < 2 ? longint'(stored_x) : longint'(x)) + (v.side ? -nx : nx));
            v.vy = clamp32((k < 2 ? longint'(stored_y) : longint'(y)) + (v.side ? -ny : ny));
            pending_vertices.insert(pending_vertices.size(), v);
         end
      end
      stored_x = x;
      stored_y = y;
      stored_attr = attr;
      stored_valid = 1'b1;
   endtask

   // Offer one point, with random idle cycles before it; valid stays high after the beat.
   task automatic send_point(input coord_type x, input coord_type y,
                             input logic [31:0] attr, input logic first);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.x <= x;
      req_if.y <= y;
      req_if.attr <= attr;
      req_if.first <= first;
      do @(posedge clock); while (!req_if.ready);
      extrude_point(x, y, attr, first);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_vertices.size() != 0) @(posedge clock);
   endtask

   // Change the half width once the block has gone quiet.
   task automatic write_half_width(input logic [HwW-1:0] value);
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      stroke_half_width = value;
   endtask

   function automatic coord_type random_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return coord_type'($urandom_range(255)) - 128;
         default: return coord_type'($urandom_range(32'h00ffffff)) - 32'sh00800000;
      endcase
   endfunction

   task automatic test_directed();
      // A point without first right after reset is only stored.
      send_point(32'sh00010000, 32'sh00020000, 32'h00000000, 1'b0);
      send_point(32'sh00050000, 32'sh00020000, 32'hffffffff, 1'b0);
      send_point(32'sh00050000, 32'sh00020000, 32'h5a5a5a5a, 1'b0);
      send_point(32'sh00050000, -32'sh00030000, 32'ha5a5a5a5, 1'b0);
      send_point(-32'sh00010000, -32'sh00060000, 32'h12345678, 1'b0);
      send_point(32'sh00000000, 32'sh00000000, 32'h0, 1'b1);
      send_point(-32'sh00020000, 32'sh00040000, 32'h1, 1'b0);
      // Extremes of the coordinate range and a full-range segment.
      send_point(32'h80000000, 32'h80000000, 32'h2, 1'b1);
      send_point(32'h7fffffff, 32'h7fffffff, 32'h3, 1'b0);
      send_point(32'h80000000, 32'h7fffffff, 32'h4, 1'b0);
      send_point(32'h7fffffff, 32'h80000000, 32'h5, 1'b0);
      send_point(32'h00000001, 32'h00000000, 32'h6, 1'b0);
      send_point(32'h00000000, 32'h00000001, 32'h7, 1'b0);
      send_point(32'h00000000, 32'h00000001, 32'h8, 1'b0);
      write_half_width(31'h7fffffff);
      send_point(32'h7fff0000, 32'h7fff0000, 32'h9, 1'b1);
      send_point(32'h7fff0000, 32'h7fff0000, 32'ha, 1'b0);
      send_point(32'h80010000, 32'h80010000, 32'hb, 1'b0);
      send_point(32'h80010000, 32'h7fff0000, 32'hc, 1'b0);
      write_half_width(31'h0);
      send_point(32'sh00030000, 32'sh00070000, 32'hd, 1'b1);
      send_point(32'sh00090000, 32'sh00010000, 32'he, 1'b0);
      send_point(32'sh00090000, 32'sh00010000, 32'hf, 1'b0);
   endtask

   // Mostly well-formed polylines, with some stray points mixed in.
   task automatic test_random_lines(input int count);
      int sent;
      int line_len;
      coord_type px;
      coord_type py;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 10) begin
            send_point($urandom, $urandom, $urandom, 1'($urandom_range(1)));
            sent++;
         end else begin
            line_len = $urandom_range(2, 8);
            px = random_coord();
            py = random_coord();
            send_point(px, py, $urandom, 1'b1);
            for (int k = 1; k < line_len; k++) begin
               if ($urandom_range(9) == 0) begin
                  px = $urandom;
                  py = $urandom;
               end else if ($urandom_range(9) != 0) begin
                  px = px + (coord_type'($urandom_range(32'h000fffff)) - 32'sh00080000);
                  py = py + (coord_type'($urandom_range(32'h000fffff)) - 32'sh00080000);
               end
               send_point(px, py, $urandom, 1'b0);
            end
            sent += line_len;
         end
      end
   endtask

   // Hold the receiver off for a long stretch while points keep coming.
   task automatic test_backpressure();
      fork
         begin
            receiver_hold <= 1'b1;
            repeat (600) @(posedge clock);
            receiver_hold <= 1'b0;
         end
      join_none
      send_point(32'sh00010000, 32'sh00010000, $urandom, 1'b1);
      for (int k = 0; k < 8; k++) begin
         send_point(random_coord(), random_coord(), $urandom, 1'b0);
      end
   endtask

   // Let every vertex come out before sending the next line.
   task automatic test_drain_pause();
      test_random_lines(6);
      wait_drained();
      test_random_lines(6);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      write_half_width(HwReset);
      sender_idle_pct = 12;
      receiver_idle_pct = 66;
      test_random_lines(110);
      test_backpressure();
      write_half_width(31'($urandom_range(32'h000fffff)));
      sender_idle_pct = 66;
      receiver_idle_pct = 12;
      test_random_lines(110);
      test_drain_pause();
      write_half_width(31'($urandom));
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_random_lines(110);
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- polyline_stroke_extruder_unit.f -----
sv/pse_pkg.sv
sv/pse_if.sv
sv/pse_front.sv
sv/pse_back.sv
sv/polyline_stroke_extruder_unit.sv
sim/testbench.sv
